// ----- src/ffsa_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the first-fit segment allocator
package ffsa_pkg;

    localparam int ADDR_W = 16;
    localparam int LEN_W  = 17;
    localparam int SUM_W  = 19;
    localparam logic [LEN_W-1:0] SPACE_MAX = 17'h10000;
    localparam logic [LEN_W-1:0] UNITS_MAX = 17'h1FFFF;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_DROP_A,
        S_DROP_B,
        S_CLIP,
        S_PUT,
        S_LIVE,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        FC_HOLD,
        FC_LOAD,
        FC_DROP,
        FC_PUT
    } fcode_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } fblk_t;

    typedef struct packed {
        fcode_t            code;
        logic [ADDR_W-1:0] key;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  size;
    } fcmd_t;

    typedef struct packed {
        logic eq;
        logic first;
        logic prev_hit;
        logic next_hit;
    } fflag_t;

endpackage

// ----- src/ffsa_if.sv -----
`timescale 1ns / 1ps
// request and response channel interfaces
interface ffsa_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [16:0] block_size;
    logic [15:0] free_start;

    modport source (output valid, output op, output block_size, output free_start,
                    input ready);
    modport sink (input valid, input op, input block_size, input free_start,
                  output ready);
endinterface

interface ffsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] granted_start;
    logic [16:0] allocated_total;
    logic [5:0]  live_count;

    modport source (output valid, output status, output granted_start,
                    output allocated_total, output live_count, input ready);
    modport sink (input valid, input status, input granted_start,
                  input allocated_total, input live_count, output ready);
endinterface

// ----- src/ffsa_free_cell.sv -----
`timescale 1ns / 1ps
// one entry of the sorted free list, shifting with its neighbors
module ffsa_free_cell
    import ffsa_pkg::*;
#(
    parameter bit IS_HEAD = 1'b0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  fcmd_t  cmd,
    input  fblk_t  left,
    input  logic   left_lt,
    input  fblk_t  right,
    input  logic   right_lt,
    input  logic   drop_here,
    input  logic   drop_in,
    output logic   drop_out,
    input  logic   fit_in,
    output logic   fit_out,
    input  logic   put_ok,
    output fblk_t  blk,
    output logic   lt,
    output fflag_t flags
);

    fblk_t blk_reg;
    fblk_t blk_next;
    logic  ge;
    logic  ends_at;
    logic  starts_at;
    logic  eq;

    assign blk       = blk_reg;
    assign lt        = blk_reg.valid && (blk_reg.start < cmd.key);
    assign eq        = blk_reg.valid && (blk_reg.start == cmd.key);
    assign ge        = blk_reg.valid && (blk_reg.len >= cmd.size);
    assign ends_at   = ({1'b0, blk_reg.start} + blk_reg.len) == {1'b0, cmd.key};
    assign starts_at = {1'b0, blk_reg.start} == ({1'b0, cmd.key} + cmd.size);
    assign drop_out  = drop_in | drop_here;
    assign fit_out   = fit_in | ge;

    assign flags.eq       = eq;
    assign flags.first    = ge && !fit_in;
    assign flags.prev_hit = lt && !right_lt && ends_at;
    assign flags.next_hit = blk_reg.valid && !lt && left_lt && starts_at;

    always_comb
    begin
        blk_next = blk_reg;
        case (cmd.code)
            FC_LOAD:
            begin
                if (IS_HEAD)
                begin
                    blk_next.valid = (cmd.len != '0);
                    blk_next.start = '0;
                    blk_next.len   = cmd.len;
                end
                else
                begin
                    blk_next.valid = 1'b0;
                end
            end
            FC_DROP:
            begin
                if (drop_in || drop_here)
                begin
                    blk_next = right;
                end
            end
            FC_PUT:
            begin
                if (eq)
                begin
                    blk_next.len = cmd.len;
                end
                else if (put_ok && !lt)
                begin
                    if (left_lt)
                    begin
                        blk_next.valid = 1'b1;
                        blk_next.start = cmd.key;
                        blk_next.len   = cmd.len;
                    end
                    else
                    begin
                        blk_next = left;
                    end
                end
            end
            default:
            begin
                blk_next = blk_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_reg.valid <= IS_HEAD;
            blk_reg.start <= '0;
            blk_reg.len   <= IS_HEAD ? SPACE_MAX : '0;
        end
        else
        begin
            blk_reg <= blk_next;
        end
    end

endmodule

// ----- src/ffsa_live_cell.sv -----
`timescale 1ns / 1ps
// one slot of the live allocation table
module ffsa_live_cell
    import ffsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] key,
    input  logic              set_en,
    input  logic              clr_en,
    input  logic              free_in,
    output logic              free_out,
    output logic              match
);

    logic              valid_reg;
    logic              valid_next;
    logic [ADDR_W-1:0] start_reg;
    logic              pick;

    assign pick     = !valid_reg && !free_in;
    assign free_out = free_in | !valid_reg;
    assign match    = valid_reg && (start_reg == key);

    always_comb
    begin
        valid_next = valid_reg;
        if (clr_en)
        begin
            valid_next = 1'b0;
        end
        else if (set_en && pick)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (set_en && pick)
        begin
            start_reg <= key;
        end
    end

endmodule

// ----- src/first_fit_segment_allocator_top.sv -----
`timescale 1ns / 1ps
// first-fit segment allocator: sequencer, free-list cell row and live table
//
// req channel carries one word per request: op (0 allocate, 1 free),
// block_size and free_start. rsp returns one word per request: status,
// granted_start, allocated_total and live_count.
// cfg_wr_en / cfg_wr_data write memory_size; the free list becomes one
// block covering the space (no block for zero). write only while no request is in flight.
// a successful request walks the free-list row one operation a cycle,
// save for a wait at the result step: find, drop, drop, clip, insert,
// live table update, result, and the output register then takes the word.
// a new request is taken only once the last has left the result step.
// early exits (table full, no space, start not found) skip to the result.
// the result sits in an output register; while rsp is stalled the
// next request is still taken and runs up to its result step, where
// it waits for the register to drain.
// reset gives a 65536-unit space as one free block, an empty live
// table and zero counters; no clearing pass is needed.
module first_fit_segment_allocator_top
    import ffsa_pkg::*;
#(
    parameter int MAX_ALLOCS      = 32,
    parameter int MAX_FREE_BLOCKS = 33
)
(
    input  logic        clk,
    input  logic        rst_n,
    ffsa_req_if.sink    req,
    ffsa_rsp_if.source  rsp,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data
);

    localparam int NF    = MAX_FREE_BLOCKS;
    localparam int NA    = MAX_ALLOCS;
    localparam int CNT_W = $clog2(NA + 1);

    state_t state_reg, state_next;

    logic              op_reg;
    logic [LEN_W-1:0]  size_reg;
    logic [ADDR_W-1:0] fs_reg;
    logic [LEN_W-1:0]  memsize_reg;
    status_t           status_reg, status_next;
    logic [ADDR_W-1:0] granted_reg, granted_next;
    logic [NF-1:0]     dropa_reg, dropa_next;
    logic [NF-1:0]     dropb_reg, dropb_next;
    logic [ADDR_W-1:0] put_start_reg, put_start_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [LEN_W-1:0]  put_len_reg, put_len_next;
    logic [NA-1:0]     slot_reg, slot_next;
    logic [LEN_W-1:0]  units_reg, units_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [ADDR_W-1:0] out_granted_reg;
    logic [LEN_W-1:0]  out_units_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_load;

    fcmd_t             cmd;
    logic [NF-1:0]     drop_mask;
    fblk_t             fblk [NF];
    logic              flt [NF];
    fflag_t            fflag [NF];
    logic [NF:0]       drop_c;
    logic [NF:0]       fit_c;
    logic              put_ok;

    logic              any_first, any_eq, has_prev, has_next;
    logic [NF-1:0]     first_v, prev_v, next_v;
    fblk_t             first_blk, prev_blk, next_blk;

    logic [ADDR_W-1:0] live_key;
    logic              live_set, live_clr;
    logic [NA:0]       free_c;
    logic [NA-1:0]     match_v;
    logic [LEN_W-1:0]  limit;
    logic [LEN_W:0]    units_sum;

    assign req.ready = (state_reg == S_IDLE);

    // free-list row
    assign drop_c[0] = 1'b0;
    assign fit_c[0]  = 1'b0;
    assign put_ok    = !any_eq && !fblk[NF-1].valid;

    genvar k;
    generate
        for (k = 0; k < NF; k++)
        begin : g_free
            fblk_t left_b, right_b;
            logic  left_l, right_l;
            if (k == 0)
            begin : g_head
                assign left_b = '0;
                assign left_l = 1'b1;
            end
            else
            begin : g_mid
                assign left_b = fblk[k-1];
                assign left_l = flt[k-1];
            end
            if (k == NF - 1)
            begin : g_tail
                assign right_b = '0;
                assign right_l = 1'b0;
            end
            else
            begin : g_body
                assign right_b = fblk[k+1];
                assign right_l = flt[k+1];
            end
            ffsa_free_cell #(.IS_HEAD(k == 0)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .left      (left_b),
                .left_lt   (left_l),
                .right     (right_b),
                .right_lt  (right_l),
                .drop_here (drop_mask[k]),
                .drop_in   (drop_c[k]),
                .drop_out  (drop_c[k+1]),
                .fit_in    (fit_c[k]),
                .fit_out   (fit_c[k+1]),
                .put_ok    (put_ok),
                .blk       (fblk[k]),
                .lt        (flt[k]),
                .flags     (fflag[k])
            );
        end

        for (k = 0; k < NA; k++)
        begin : g_live
            ffsa_live_cell u_live (
                .clk      (clk),
                .rst_n    (rst_n),
                .key      (live_key),
                .set_en   (live_set),
                .clr_en   (live_clr && slot_reg[k]),
                .free_in  (free_c[k]),
                .free_out (free_c[k+1]),
                .match    (match_v[k])
            );
        end
    endgenerate

    assign free_c[0] = 1'b0;

    // selection over the row
    always_comb
    begin
        any_eq    = 1'b0;
        first_blk = '0;
        prev_blk  = '0;
        next_blk  = '0;
        for (int i = 0; i < NF; i++)
        begin
            first_v[i] = fflag[i].first;
            prev_v[i]  = fflag[i].prev_hit;
            next_v[i]  = fflag[i].next_hit;
            any_eq     = any_eq | fflag[i].eq;
            first_blk  = first_blk | (fblk[i] & {$bits(fblk_t){first_v[i]}});
            prev_blk   = prev_blk | (fblk[i] & {$bits(fblk_t){prev_v[i]}});
            next_blk   = next_blk | (fblk[i] & {$bits(fblk_t){next_v[i]}});
        end
        any_first = |first_v;
        has_prev  = |prev_v;
        has_next  = |next_v;
    end

    // row command
    always_comb
    begin
        cmd.code  = FC_HOLD;
        cmd.key   = (state_reg == S_PUT) ? put_start_reg : fs_reg;
        cmd.len   = put_len_reg;
        cmd.size  = size_reg;
        drop_mask = '0;
        if (cfg_wr_en)
        begin
            cmd.code = FC_LOAD;
            cmd.len  = cfg_wr_data[16] ? SPACE_MAX : cfg_wr_data;
        end
        else
        begin
            case (state_reg)
                S_DROP_A:
                begin
                    cmd.code  = FC_DROP;
                    drop_mask = dropa_reg;
                end
                S_DROP_B:
                begin
                    cmd.code  = FC_DROP;
                    drop_mask = dropb_reg;
                end
                S_PUT:
                begin
                    cmd.code = (put_len_reg != '0) ? FC_PUT : FC_HOLD;
                end
                default:
                begin
                    cmd.code = FC_HOLD;
                end
            endcase
        end
    end

    assign live_key  = (state_reg == S_LIVE) ? granted_reg : fs_reg;
    assign live_set  = (state_reg == S_LIVE) && !op_reg && (status_reg == ST_OK)
                       && !(|match_v);
    assign live_clr  = (state_reg == S_LIVE) && op_reg && (status_reg == ST_OK);
    assign limit     = SPACE_MAX - {1'b0, put_start_reg};
    assign units_sum = {1'b0, units_reg} + {1'b0, size_reg};
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        dropa_next     = dropa_reg;
        dropb_next     = dropb_reg;
        put_start_next = put_start_reg;
        sum_next       = sum_reg;
        put_len_next   = put_len_reg;
        slot_next      = slot_reg;
        units_next     = units_reg;
        count_next     = count_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                status_next  = ST_OK;
                granted_next = '0;
                dropa_next   = '0;
                dropb_next   = '0;
                state_next   = S_DROP_A;
                if (!op_reg)
                begin
                    if (count_reg >= CNT_W'(NA))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else if (size_reg == '0 || !any_first)
                    begin
                        status_next = ST_NO_SPACE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        granted_next   = first_blk.start;
                        dropa_next     = first_v;
                        put_start_next = first_blk.start + size_reg[ADDR_W-1:0];
                        sum_next       = SUM_W'(first_blk.len - size_reg);
                    end
                end
                else
                begin
                    if (({1'b0, fs_reg} >= memsize_reg) || !(|match_v))
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        slot_next      = match_v;
                        dropa_next     = has_next ? next_v : '0;
                        dropb_next     = has_prev ? prev_v : '0;
                        put_start_next = has_prev ? prev_blk.start : fs_reg;
                        sum_next       = SUM_W'(size_reg)
                                       + (has_next ? SUM_W'(next_blk.len) : '0)
                                       + (has_prev ? SUM_W'(prev_blk.len) : '0);
                    end
                end
            end
            S_DROP_A:
            begin
                state_next = S_DROP_B;
            end
            S_DROP_B:
            begin
                state_next = S_CLIP;
            end
            S_CLIP:
            begin
                put_len_next = (sum_reg > SUM_W'(limit)) ? limit : sum_reg[LEN_W-1:0];
                state_next   = S_PUT;
            end
            S_PUT:
            begin
                state_next = S_LIVE;
            end
            S_LIVE:
            begin
                if (!op_reg)
                begin
                    units_next = units_sum[LEN_W] ? UNITS_MAX : units_sum[LEN_W-1:0];
                    if (live_set && !free_c[NA] == 1'b0)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                begin
                    units_next = (units_reg > size_reg) ? units_reg - size_reg : '0;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            memsize_reg   <= SPACE_MAX;
            units_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            units_reg <= units_next;
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                memsize_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg   <= req.op;
            size_reg <= req.block_size;
            fs_reg   <= req.free_start;
        end
        status_reg    <= status_next;
        granted_reg   <= granted_next;
        dropa_reg     <= dropa_next;
        dropb_reg     <= dropb_next;
        put_start_reg <= put_start_next;
        sum_reg       <= sum_next;
        put_len_reg   <= put_len_next;
        slot_reg      <= slot_next;
        if (out_load)
        begin
            out_status_reg  <= status_reg;
            out_granted_reg <= granted_reg;
            out_units_reg   <= units_reg;
            out_count_reg   <= count_reg;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.granted_start   = out_granted_reg;
    assign rsp.allocated_total = out_units_reg;
    assign rsp.live_count      = 6'(out_count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NA))
        else $error("live count above table size");

    a_accept_find: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == S_FIND)
        else $error("accepted word did not start a search");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside result step");

    a_list_packed: assert property (@(posedge clk) disable iff (!rst_n)
        fblk[1].valid |-> fblk[0].valid)
        else $error("free list has a hole at its head");

    a_drop_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DROP_A |-> $onehot0(dropa_reg))
        else $error("more than one free entry dropped");

endmodule

// ----- tb/ffsa_alloc_checker.sv -----
`timescale 1ns / 1ps
// checker: predicts allocator results from accepted request words and compares them
module ffsa_alloc_checker
    import ffsa_pkg::*;
#(
    parameter int MAX_ALLOCS      = 32,
    parameter int MAX_FREE_BLOCKS = 33
)
(
    input  logic        clk,
    input  logic        rst_n,
    ffsa_req_if.sink    req,
    ffsa_rsp_if.sink    rsp,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        status_t     status;
        logic [15:0] start;
        logic [16:0] total;
        logic [5:0]  live;
    } alloc_word_t;

    alloc_word_t result_q[$];
    longint unsigned mem_units;
    longint unsigned fl_start[MAX_FREE_BLOCKS];
    longint unsigned fl_len[MAX_FREE_BLOCKS];
    int              fl_count;
    longint unsigned tbl_start[MAX_ALLOCS];
    bit              tbl_valid[MAX_ALLOCS];
    longint unsigned units_used;
    int              live_num;

    assign pending = result_q.size();

    function automatic longint unsigned space_units();
        return (mem_units < 65536) ? mem_units : 65536;
    endfunction

    function automatic void fl_remove(int pos);
        if (pos >= fl_count)
            return;
        for (int k = pos; k + 1 < fl_count; k++)
        begin
            fl_start[k] = fl_start[k+1];
            fl_len[k]   = fl_len[k+1];
        end
        fl_count--;
    endfunction

    function automatic void fl_insert(longint unsigned s, longint unsigned l);
        int pos;
        pos = 0;
        if (l == 0)
            return;
        while (pos < fl_count && fl_start[pos] < s)
            pos++;
        if (pos < fl_count && fl_start[pos] == s)
        begin
            fl_len[pos] = l;
            return;
        end
        if (fl_count >= MAX_FREE_BLOCKS)
            return;
        for (int k = fl_count; k > pos; k--)
        begin
            fl_start[k] = fl_start[k-1];
            fl_len[k]   = fl_len[k-1];
        end
        fl_start[pos] = s;
        fl_len[pos]   = l;
        fl_count++;
    endfunction

    function automatic void rebuild_space();
        fl_count = 0;
        fl_insert(0, space_units());
    endfunction

    function automatic alloc_word_t predict_alloc(logic op, logic [16:0] sz_in,
                                                  logic [15:0] fs_in);
        alloc_word_t     w;
        longint unsigned sz, fs, s, l, ns, nl;
        int              i, slot, nx;
        bit              has_prev, has_next;
        sz = 64'(sz_in);
        fs = 64'(fs_in);
        w.status = ST_OK;
        w.start  = '0;
        if (op == 1'b0)
        begin
            if (live_num >= MAX_ALLOCS)
                w.status = ST_FULL;
            else if (sz == 0)
                w.status = ST_NO_SPACE;
            else
            begin
                for (i = 0; i < fl_count; i++)
                    if (fl_len[i] >= sz)
                        break;
                if (i == fl_count)
                    w.status = ST_NO_SPACE;
                else
                begin
                    s = fl_start[i];
                    l = fl_len[i];
                    fl_remove(i);
                    fl_insert(s + sz, l - sz);
                    units_used += sz;
                    if (units_used > 131071)
                        units_used = 131071;
                    slot = MAX_ALLOCS;
                    for (i = 0; i < MAX_ALLOCS; i++)
                        if (tbl_valid[i] && tbl_start[i] == s)
                        begin
                            slot = i;
                            break;
                        end
                    if (slot == MAX_ALLOCS)
                        for (i = 0; i < MAX_ALLOCS; i++)
                            if (!tbl_valid[i])
                            begin
                                tbl_valid[i] = 1;
                                tbl_start[i] = s;
                                live_num++;
                                break;
                            end
                    w.start = s[15:0];
                end
            end
        end
        else
        begin
            slot = MAX_ALLOCS;
            if (fs < space_units())
                for (i = 0; i < MAX_ALLOCS; i++)
                    if (tbl_valid[i] && tbl_start[i] == fs)
                    begin
                        slot = i;
                        break;
                    end
            if (slot == MAX_ALLOCS)
                w.status = ST_NOT_FOUND;
            else
            begin
                nx = 0;
                ns = fs;
                nl = sz;
                while (nx < fl_count && fl_start[nx] < fs)
                    nx++;
                has_prev = nx > 0 && fl_start[nx-1] + fl_len[nx-1] == fs;
                has_next = nx < fl_count && fs + sz == fl_start[nx];
                if (has_next)
                begin
                    nl += fl_len[nx];
                    fl_remove(nx);
                end
                if (has_prev)
                begin
                    ns = fl_start[nx-1];
                    nl += fl_len[nx-1];
                    fl_remove(nx - 1);
                end
                if (nl > 65536 - ns)
                    nl = 65536 - ns;
                fl_insert(ns, nl);
                units_used = (units_used > sz) ? units_used - sz : 0;
                tbl_valid[slot] = 0;
                tbl_start[slot] = 0;
                if (live_num > 0)
                    live_num--;
            end
        end
        w.total = units_used[16:0];
        w.live  = live_num[5:0];
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_word_t got, want;
        if (!rst_n)
        begin
            result_q.delete();
            fail_count = 0;
            mem_units  = 65536;
            units_used = 0;
            live_num   = 0;
            for (int k = 0; k < MAX_ALLOCS; k++)
            begin
                tbl_valid[k] = 0;
                tbl_start[k] = 0;
            end
            rebuild_space();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mem_units = 64'(cfg_wr_data);
                rebuild_space();
            end
            if (rsp.valid && rsp.ready)
            begin
                got.status = status_t'(rsp.status);
                got.start  = rsp.granted_start;
                got.total  = rsp.allocated_total;
                got.live   = rsp.live_count;
                if (result_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word %h", got);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.status != want.status || got.start != want.start ||
                        got.total != want.total || got.live != want.live)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("exp st=%0d start=%0d total=%0d live=%0d",
                                     want.status, want.start, want.total, want.live);
                            $display("got st=%0d start=%0d total=%0d live=%0d",
                                     got.status, got.start, got.total, got.live);
                        end
                    end
                end
            end
            if (req.valid && req.ready)
                result_q.push_back(predict_alloc(req.op, req.block_size, req.free_start));
        end
    end

endmodule

// ----- tb/tb_first_fit_segment_allocator_top.sv -----
`timescale 1ns / 1ps
// testbench top: stimulus, configuration phases and verdict for the allocator
module tb_first_fit_segment_allocator_top
    import ffsa_pkg::*;
;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [16:0] cfg_wr_data;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          hold_off;
    bit          stall_en;
    int          words_sent;
    logic [15:0] granted_log[$];

    ffsa_req_if req_ch();
    ffsa_rsp_if rsp_ch();

    first_fit_segment_allocator_top u_top (
        .clk(clk), .rst_n(rst_n), .req(req_ch.sink), .rsp(rsp_ch.source),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    ffsa_alloc_checker u_chk (
        .clk(clk), .rst_n(rst_n), .req(req_ch.sink), .rsp(rsp_ch.sink),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    // receiver stall pattern plus a long hold-off
    always @(negedge clk)
    begin
        if (hold_off)
            rsp_ch.ready <= 1'b0;
        else if (stall_en)
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        else
            rsp_ch.ready <= 1'b1;
    end

    // the checker sees granted starts too late for stimulus, so track them here
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == ST_OK &&
            rsp_ch.live_count != 0 && granted_log.size() < 64)
            granted_log.push_back(rsp_ch.granted_start);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (hold_off)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000)
            begin
                $display("first_fit_segment_allocator_top: mismatch");
                $finish;
            end
        end
    end

    task automatic send_word(logic op, logic [16:0] sz, logic [15:0] fs);
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.block_size <= sz;
        req_ch.free_start <= fs;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic gap_or_stay(bit bursty);
        if (bursty && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    task automatic drain_and_config(logic [16:0] value);
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        granted_log.delete();
        @(negedge clk);
    endtask

    task automatic random_word(bit bursty);
        logic [16:0] sz;
        logic [15:0] fs;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            sz = 17'($urandom_range(0, 17'h1FFFF));
        else if (pick < 40)
            sz = 17'($urandom_range(1, 16));
        else
            sz = 17'($urandom_range(1, 4096));
        if (granted_log.size() != 0 && $urandom_range(0, 9) < 8)
            fs = granted_log[$urandom_range(0, granted_log.size() - 1)];
        else
            fs = 16'($urandom_range(0, 16'hFFFF));
        if ($urandom_range(0, 1) == 0)
            send_word(OP_ALLOC, sz, fs);
        else
            send_word(OP_FREE, sz, fs);
        gap_or_stay(bursty);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        req_ch.valid      = 1'b0;
        req_ch.op         = OP_ALLOC;
        req_ch.block_size = '0;
        req_ch.free_start = '0;
        hold_off          = 1'b0;
        stall_en          = 1'b0;
        words_sent        = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, zero size, unknown starts, merges, table full
        send_word(OP_ALLOC, 17'd0, 16'd0);
        send_word(OP_ALLOC, 17'h1FFFF, 16'hFFFF);
        send_word(OP_ALLOC, 17'd100, 16'd0);
        send_word(OP_ALLOC, 17'd200, 16'd0);
        send_word(OP_ALLOC, 17'd300, 16'd0);
        send_word(OP_FREE, 17'd100, 16'd0);
        send_word(OP_FREE, 17'd300, 16'd300);
        send_word(OP_FREE, 17'd200, 16'd100);
        send_word(OP_FREE, 17'd5, 16'hFFFF);
        send_word(OP_ALLOC, 17'h10000, 16'd0);
        send_word(OP_FREE, 17'h10000, 16'd0);
        send_word(OP_ALLOC, 17'd1, 16'd0);
        send_word(OP_FREE, 17'h1FFFF, 16'd0);
        for (int k = 0; k < 34; k++)
            send_word(OP_ALLOC, 17'd1, 16'd0);

        drain_and_config(17'd0);
        send_word(OP_ALLOC, 17'd1, 16'd0);
        send_word(OP_FREE, 17'd1, 16'd0);
        drain_and_config(17'h1FFFF);
        for (int k = 0; k < 40; k++)
            send_word(OP_FREE, 17'd1, k[15:0]);

        // random phases over several sizes, with long hold-off in one
        stall_en = 1'b1;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: drain_and_config(17'd1);
                1: drain_and_config(17'd512);
                2: drain_and_config(17'h10000);
                3: drain_and_config(17'd4096);
                default: drain_and_config(17'h1FFFF);
            endcase
            if (ph == 2)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            for (int k = 0; k < 120; k++)
                random_word(ph != 2);
        end
        req_ch.valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        $display("covered %0d request words, six memory sizes incl. 0 and 131071,",
                 words_sent);
        $display("table full, merges, unknown starts and a long response stall");
        if (fail_count == 0)
            $display("first_fit_segment_allocator_top: match");
        else
            $display("first_fit_segment_allocator_top: mismatch");
        $finish;
    end

endmodule
